[rtl/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int unsigned BLOCK_FRAMES = 1024;
  localparam int unsigned MaxResults   = 8;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned OutW     = 32;
  localparam int unsigned StepW    = 35;
  localparam int unsigned PosW     = 64;
  localparam int unsigned FracW    = 32;
  localparam int unsigned FrameCntW = 32;
  localparam int unsigned CountW   = $clog2(MaxResults);
  localparam int unsigned BlockW   = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = StepW;

  localparam logic [CfgIdxW-1:0] RegStepRatio  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStereoMode = CfgIdxW'(1);

  localparam logic [StepW-1:0] StepReset = StepW'(64'h1_0000_0000);

  localparam int unsigned FqDepth = 2;
  localparam int unsigned FqPtrW  = (FqDepth > 1) ? $clog2(FqDepth) : 1;
  localparam int unsigned FqCntW  = $clog2(FqDepth + 1);

  localparam int unsigned RqDepth = 2;
  localparam int unsigned RqPtrW  = (RqDepth > 1) ? $clog2(RqDepth) : 1;
  localparam int unsigned RqCntW  = $clog2(RqDepth + 1);

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
  } frame_t;

  typedef struct packed {
    logic             clear;
    logic [StepW-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic [OutW-1:0] left;
    logic [OutW-1:0] right;
    logic            run_last;
    logic            block_end;
  } result_t;

endpackage

[rtl/lir_front.sv]
// ----------------------------------------------------------------------------
// lir_front
// Configuration registers, input request intake and frame queue.
// ----------------------------------------------------------------------------
module lir_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lir_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [lir_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [lir_pkg::SampleW-1:0] right_sample_i,
  output lir_pkg::cfg_t                 cfg_o,
  output lir_pkg::frame_t               frame_o,
  output logic                          frame_valid_o,
  input  logic                          frame_pop_i
);

  logic [lir_pkg::StepW-1:0] step_q;
  logic                      stereo_q;
  logic                      clear;

  lir_pkg::frame_t           fq_mem_q [lir_pkg::FqDepth];
  lir_pkg::frame_t           in_frame;
  logic [lir_pkg::FqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [lir_pkg::FqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [lir_pkg::FqCntW-1:0] cnt_q, cnt_d;
  logic                      accept;

  always_comb begin
    case (cfg_idx_i)
      lir_pkg::RegStepRatio:  clear = cfg_we_i;
      lir_pkg::RegStereoMode: clear = cfg_we_i;
      default:                clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= lir_pkg::StepReset;
      stereo_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lir_pkg::RegStepRatio:  step_q   <= cfg_wdata_i[lir_pkg::StepW-1:0];
        lir_pkg::RegStereoMode: stereo_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.clear = clear;
  assign cfg_o.step  = step_q;

  assign full   = (cnt_q == lir_pkg::FqCntW'(lir_pkg::FqDepth));
  assign accept = push & ~full;

  // mono: right channel takes the left sample
  assign in_frame.left  = left_sample_i;
  assign in_frame.right = stereo_q ? right_sample_i : left_sample_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fq_mem_q[wr_ptr_q] <= in_frame;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == lir_pkg::FqPtrW'(lir_pkg::FqDepth - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (frame_pop_i) begin
      rd_ptr_d = (rd_ptr_q == lir_pkg::FqPtrW'(lir_pkg::FqDepth - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    case ({accept, frame_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (clear) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign frame_valid_o = (cnt_q != '0);
  assign frame_o       = fq_mem_q[rd_ptr_q];

  a_fq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lir_pkg::FqCntW'(lir_pkg::FqDepth))
    else $error("frame queue count beyond depth");

  a_fq_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_pop_i |-> cnt_q != '0)
    else $error("frame pop from empty queue");

endmodule

[rtl/lir_back.sv]
// ----------------------------------------------------------------------------
// lir_back
// Position tracking, result queue, one interpolation per cycle unless stalled.
// ----------------------------------------------------------------------------
module lir_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lir_pkg::cfg_t               cfg_i,
  input  lir_pkg::frame_t             frame_i,
  input  logic                        frame_valid_i,
  output logic                        frame_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [lir_pkg::OutW-1:0] out_left_o,
  output logic signed [lir_pkg::OutW-1:0] out_right_o,
  output logic                        run_last_o,
  output logic                        block_end_o
);

  logic [lir_pkg::PosW-1:0]      pos_q;
  logic [lir_pkg::FrameCntW-1:0] frames_q;
  logic                          prev_valid_q;
  logic [lir_pkg::SampleW-1:0]   prev_l_q, prev_r_q;
  logic [lir_pkg::BlockW-1:0]    fill_q;
  logic [lir_pkg::CountW-1:0]    count_q;

  logic [lir_pkg::FrameCntW-1:0] rel, rel_next;
  logic [lir_pkg::PosW-1:0]      pos_next;
  logic [lir_pkg::FracW-1:0]     frac;
  logic                          ahead, emit_ok, last, block_end;
  logic                          res_push, finish, snap;
  logic signed [lir_pkg::SampleW:0] dl, dr;
  logic signed [49:0]            prod_l, prod_r;
  logic [lir_pkg::SampleW-1:0]   samp_l, samp_r;
  lir_pkg::result_t              res;

  lir_pkg::result_t              rq_mem_q [lir_pkg::RqDepth];
  logic [lir_pkg::RqPtrW-1:0]    rq_wr_q, rq_rd_q;
  logic [lir_pkg::RqCntW-1:0]    rq_cnt_q, rq_cnt_d;
  logic                          rq_full, rq_pop;

  assign rel      = pos_q[lir_pkg::PosW-1:lir_pkg::FracW] - frames_q;
  assign ahead    = ~rel[lir_pkg::FrameCntW-1];
  assign emit_ok  = (rel == '1) && prev_valid_q;
  assign frac     = pos_q[lir_pkg::FracW-1:0];
  assign pos_next = pos_q + lir_pkg::PosW'(cfg_i.step);
  assign rel_next = pos_next[lir_pkg::PosW-1:lir_pkg::FracW] - frames_q;
  assign last     = (count_q == lir_pkg::CountW'(lir_pkg::MaxResults - 1)) ||
                    (rel_next != '1);
  assign block_end = (fill_q == lir_pkg::BlockW'(lir_pkg::BLOCK_FRAMES - 1));

  assign dl = {frame_i.left[lir_pkg::SampleW-1], frame_i.left} -
              {prev_l_q[lir_pkg::SampleW-1], prev_l_q};
  assign dr = {frame_i.right[lir_pkg::SampleW-1], frame_i.right} -
              {prev_r_q[lir_pkg::SampleW-1], prev_r_q};
  assign prod_l = 50'(dl) * 50'($signed({1'b0, frac}));
  assign prod_r = 50'(dr) * 50'($signed({1'b0, frac}));
  assign samp_l = prev_l_q + prod_l[47:32];
  assign samp_r = prev_r_q + prod_r[47:32];

  assign res.left      = {samp_l, 16'h0000};
  assign res.right     = {samp_r, 16'h0000};
  assign res.run_last  = last;
  assign res.block_end = block_end;

  assign rq_full  = (rq_cnt_q == lir_pkg::RqCntW'(lir_pkg::RqDepth));
  assign res_push = frame_valid_i & emit_ok & ~rq_full;
  assign snap     = frame_valid_i & ~emit_ok & ~ahead;
  assign finish   = (res_push & last) | (frame_valid_i & ~emit_ok);
  assign frame_pop_o = finish & ~cfg_i.clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      frames_q     <= '0;
      prev_valid_q <= 1'b0;
      prev_l_q     <= '0;
      prev_r_q     <= '0;
      fill_q       <= '0;
      count_q      <= '0;
    end else if (cfg_i.clear) begin
      pos_q        <= '0;
      frames_q     <= '0;
      prev_valid_q <= 1'b0;
      prev_l_q     <= '0;
      prev_r_q     <= '0;
      fill_q       <= '0;
      count_q      <= '0;
    end else begin
      if (res_push) begin
        pos_q   <= pos_next;
        fill_q  <= block_end ? '0 : fill_q + 1'b1;
        count_q <= last ? '0 : count_q + 1'b1;
      end else if (snap) begin
        pos_q <= {frames_q, {lir_pkg::FracW{1'b0}}};
      end
      if (finish) begin
        prev_l_q     <= frame_i.left;
        prev_r_q     <= frame_i.right;
        prev_valid_q <= 1'b1;
        frames_q     <= frames_q + 1'b1;
      end
    end
  end

  assign rq_pop = pop & ~empty;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_mem_q[rq_wr_q] <= res;
    end
  end

  always_comb begin
    case ({res_push, rq_pop})
      2'b10:   rq_cnt_d = rq_cnt_q + 1'b1;
      2'b01:   rq_cnt_d = rq_cnt_q - 1'b1;
      default: rq_cnt_d = rq_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (res_push) begin
        rq_wr_q <= (rq_wr_q == lir_pkg::RqPtrW'(lir_pkg::RqDepth - 1)) ? '0 :
                   rq_wr_q + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_q <= (rq_rd_q == lir_pkg::RqPtrW'(lir_pkg::RqDepth - 1)) ? '0 :
                   rq_rd_q + 1'b1;
      end
      rq_cnt_q <= rq_cnt_d;
    end
  end

  assign empty       = (rq_cnt_q == '0);
  assign out_left_o  = rq_mem_q[rq_rd_q].left;
  assign out_right_o = rq_mem_q[rq_rd_q].right;
  assign run_last_o  = rq_mem_q[rq_rd_q].run_last;
  assign block_end_o = rq_mem_q[rq_rd_q].block_end;

  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.clear |=> pos_q == '0 && frames_q == '0 && !prev_valid_q)
    else $error("state not cleared by config write");

  a_emit_needs_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> prev_valid_q && frame_valid_i && !rq_full)
    else $error("result without stored frame or queue space");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && !last && !cfg_i.clear |=> count_q != '0 && frame_valid_i)
    else $error("run ended without last flag");

  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= lir_pkg::RqCntW'(lir_pkg::RqDepth))
    else $error("result queue count beyond depth");

endmodule

[rtl/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation rate converter, 16-bit frames in, 32-bit samples out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  frames    in         push / full        left_sample_i, right_sample_i
//  results   out        pop / empty        out_left_o, out_right_o,
//                                          run_last_o, block_end_o
//  config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
//  A frame yields between 1 and 8 results, or none at all; the interpolation
//  step sets how many.
//  A pushed frame is held in the frame queue, its results in the result queue.
//  Reset and any config write clear the frame queue and back-end state with
//  no clearing pass; only reset clears the result queue. full rises when the
//  two-entry frame queue fills; a full result queue stalls the back end only.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lir_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [lir_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic signed [lir_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [lir_pkg::SampleW-1:0] right_sample_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [lir_pkg::OutW-1:0]    out_left_o,
  output logic signed [lir_pkg::OutW-1:0]    out_right_o,
  output logic                               run_last_o,
  output logic                               block_end_o
);

  lir_pkg::cfg_t   cfg;
  lir_pkg::frame_t frame;
  logic            frame_valid;
  logic            frame_pop;

  lir_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .cfg_o          (cfg),
    .frame_o        (frame),
    .frame_valid_o  (frame_valid),
    .frame_pop_i    (frame_pop)
  );

  lir_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .frame_i       (frame),
    .frame_valid_i (frame_valid),
    .frame_pop_o   (frame_pop),
    .empty         (empty),
    .pop           (pop),
    .out_left_o    (out_left_o),
    .out_right_o   (out_right_o),
    .run_last_o    (run_last_o),
    .block_end_o   (block_end_o)
  );

endmodule

[dv/tb_linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler
// Self-checking bench for the linear interpolation resampler: frames go in
// through the push/full queue, each one is run through a bit-accurate
// predictor of the Q32 position walk and the interpolation, and every
// popped output frame is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_interp_resampler;

  typedef struct {
    logic [lir_pkg::OutW-1:0] left;
    logic [lir_pkg::OutW-1:0] right;
    logic                     run_last;
    logic                     block_end;
  } out_frame_t;

  localparam logic [lir_pkg::StepW-1:0] StepEighth = lir_pkg::StepW'(64'h0_2000_0000);
  localparam logic [lir_pkg::StepW-1:0] StepFour   = lir_pkg::StepW'(64'h4_0000_0000);
  localparam logic [lir_pkg::StepW-1:0] StepMax    = {lir_pkg::StepW{1'b1}};
  localparam int unsigned               SettleCycles = 20;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [lir_pkg::CfgIdxW-1:0]        cfg_idx_i;
  logic [lir_pkg::CfgDataW-1:0]       cfg_wdata_i;
  logic                               push;
  logic                               full;
  logic signed [lir_pkg::SampleW-1:0] left_sample_i;
  logic signed [lir_pkg::SampleW-1:0] right_sample_i;
  logic                               empty;
  logic                               pop;
  logic signed [lir_pkg::OutW-1:0]    out_left_o;
  logic signed [lir_pkg::OutW-1:0]    out_right_o;
  logic                               run_last_o;
  logic                               block_end_o;

  linear_interp_resampler dut (.*);

  // resampler state as predicted
  logic [lir_pkg::StepW-1:0]          ratio;
  logic                               stereo;
  logic [lir_pkg::PosW-1:0]           pos_q32;
  logic [lir_pkg::FrameCntW-1:0]      frame_cnt;
  logic                               prev_valid;
  logic signed [lir_pkg::SampleW-1:0] prev_left;
  logic signed [lir_pkg::SampleW-1:0] prev_right;
  int unsigned                        block_cnt;

  out_frame_t  pending_frames[$];
  bit          no_idle;
  int unsigned errors;
  int unsigned frames_sent;
  int unsigned frames_checked;
  int unsigned blocks_seen;
  int unsigned settings_used;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [lir_pkg::OutW-1:0] lerp(
      logic signed [lir_pkg::SampleW-1:0] a,
      logic signed [lir_pkg::SampleW-1:0] b,
      logic [lir_pkg::FracW-1:0] frac);
    longint diff;
    longint weight;
    longint acc;
    diff   = b;
    diff   = diff - a;
    weight = frac;
    acc    = a;
    acc    = acc + ((diff * weight) >>> 32);
    return {acc[lir_pkg::SampleW-1:0], 16'h0000};
  endfunction

  function automatic void clear_resampler();
    pos_q32    = '0;
    frame_cnt  = '0;
    prev_valid = 1'b0;
    prev_left  = '0;
    prev_right = '0;
    block_cnt  = 0;
  endfunction

  function automatic void resample_frame(logic signed [lir_pkg::SampleW-1:0] l,
                                         logic signed [lir_pkg::SampleW-1:0] r);
    out_frame_t                         run[lir_pkg::MaxResults];
    int                                 n;
    logic [lir_pkg::FrameCntW-1:0]      rel;
    logic signed [lir_pkg::SampleW-1:0] cur_r;
    n     = 0;
    cur_r = stereo ? r : l;
    while (n < lir_pkg::MaxResults) begin
      rel = pos_q32[lir_pkg::PosW-1:lir_pkg::FracW] - frame_cnt;
      if (!rel[lir_pkg::FrameCntW-1]) break;
      if (rel != '1 || !prev_valid) begin
        pos_q32 = {frame_cnt, {lir_pkg::FracW{1'b0}}};
        break;
      end
      run[n].left      = lerp(prev_left, l, pos_q32[lir_pkg::FracW-1:0]);
      run[n].right     = lerp(prev_right, cur_r, pos_q32[lir_pkg::FracW-1:0]);
      run[n].run_last  = 1'b0;
      block_cnt++;
      run[n].block_end = (block_cnt >= lir_pkg::BLOCK_FRAMES);
      if (run[n].block_end) block_cnt = 0;
      pos_q32 = pos_q32 + lir_pkg::PosW'(ratio);
      n++;
    end
    if (n > 0) run[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) pending_frames.push_back(run[i]);
    prev_left  = l;
    prev_right = cur_r;
    prev_valid = 1'b1;
    frame_cnt  = frame_cnt + 1'b1;
  endfunction

  always @(negedge clk_i) begin
    pop = no_idle || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    out_frame_t exp_frame;
    if (rst_ni && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected output frame left=%h right=%h", out_left_o, out_right_o);
        errors++;
      end else begin
        exp_frame = pending_frames.pop_front();
        frames_checked++;
        if (block_end_o) blocks_seen++;
        if (out_left_o !== exp_frame.left) begin
          $error("out_left: expected %h, got %h", exp_frame.left, out_left_o);
          errors++;
        end
        if (out_right_o !== exp_frame.right) begin
          $error("out_right: expected %h, got %h", exp_frame.right, out_right_o);
          errors++;
        end
        if (run_last_o !== exp_frame.run_last) begin
          $error("run_last: expected %b, got %b", exp_frame.run_last, run_last_o);
          errors++;
        end
        if (block_end_o !== exp_frame.block_end) begin
          $error("block_end: expected %b, got %b", exp_frame.block_end, block_end_o);
          errors++;
        end
      end
    end
  end

  task automatic send_frame(logic signed [lir_pkg::SampleW-1:0] l,
                            logic signed [lir_pkg::SampleW-1:0] r);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(99) < 27) begin
        push = 1'b0;
      end else begin
        push           = 1'b1;
        left_sample_i  = l;
        right_sample_i = r;
        @(posedge clk_i);
        if (!full) begin
          resample_frame(l, r);
          frames_sent++;
          done = 1'b1;
        end
      end
    end
  endtask

  // hold the sender until every predicted output has been popped
  task automatic drain_outputs();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lir_pkg::CfgIdxW-1:0] idx,
                           logic [lir_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    case (idx)
      lir_pkg::RegStepRatio:  ratio  = data[lir_pkg::StepW-1:0];
      lir_pkg::RegStereoMode: stereo = data[0];
      default: ;
    endcase
    clear_resampler();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_mode(logic [lir_pkg::StepW-1:0] r, logic st);
    drain_outputs();
    write_reg(lir_pkg::RegStepRatio, lir_pkg::CfgDataW'(r));
    write_reg(lir_pkg::RegStereoMode, lir_pkg::CfgDataW'(st));
    settings_used++;
  endtask

  function automatic logic signed [lir_pkg::SampleW-1:0] pick_sample(
      logic signed [lir_pkg::SampleW-1:0] near);
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3, 4: return near + lir_pkg::SampleW'($urandom_range(64)) -
                      lir_pkg::SampleW'(32);
      default: return lir_pkg::SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [lir_pkg::StepW-1:0] pick_ratio();
    logic [63:0] span;
    span = 64'(StepFour) - 64'(StepEighth) + 64'd1;
    case ($urandom_range(11))
      0:       return '0;
      1:       return StepMax;
      2:       return StepEighth;
      3:       return StepFour;
      4:       return lir_pkg::StepW'(64'h0_EB33_3333);
      default: return lir_pkg::StepW'(({$urandom, $urandom} % span) + 64'(StepEighth));
    endcase
  endfunction

  task automatic test_default_settings();
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'shffff, 16'sh0001);
    send_frame(16'sh0001, 16'shffff);
  endtask

  task automatic test_fractional_extremes();
    set_mode(lir_pkg::StepW'(64'h0_C000_0000), 1'b1);
    for (int i = 0; i < 6; i++) begin
      if (i[0]) send_frame(16'sh8000, 16'sh7fff);
      else send_frame(16'sh7fff, 16'sh8000);
    end
  endtask

  task automatic test_mono_upsample_cap();
    set_mode(StepEighth, 1'b0);
    send_frame(16'sh8000, 16'sh1234);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh0000, 16'sh7fff);
    send_frame(16'shffff, 16'sh5555);
  endtask

  task automatic test_zero_step();
    set_mode('0, 1'b1);
    send_frame(16'sh0100, 16'shff00);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0003, 16'shfffd);
  endtask

  task automatic test_max_step();
    set_mode(StepMax, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_frame(lir_pkg::SampleW'($urandom), lir_pkg::SampleW'($urandom));
    end
  endtask

  task automatic test_block_boundary();
    logic signed [lir_pkg::SampleW-1:0] l;
    logic signed [lir_pkg::SampleW-1:0] r;
    l = '0;
    r = '0;
    set_mode(StepEighth, 1'b1);
    no_idle = 1'b1;
    for (int i = 0; i < 140; i++) begin
      l = pick_sample(l);
      r = pick_sample(r);
      send_frame(l, r);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_ratios();
    logic signed [lir_pkg::SampleW-1:0] l;
    logic signed [lir_pkg::SampleW-1:0] r;
    l = '0;
    r = '0;
    for (int p = 0; p < 8; p++) begin
      set_mode(pick_ratio(), 1'($urandom));
      for (int i = 0; i < 40; i++) begin
        if (i == 20 && p[0]) drain_outputs();
        l = pick_sample(l);
        r = pick_sample(r);
        send_frame(l, r);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = lir_pkg::RegStepRatio;
    cfg_wdata_i    = '0;
    push           = 1'b0;
    pop            = 1'b0;
    left_sample_i  = '0;
    right_sample_i = '0;
    no_idle        = 1'b0;
    errors         = 0;
    frames_sent    = 0;
    frames_checked = 0;
    blocks_seen    = 0;
    settings_used  = 1;
    ratio          = lir_pkg::StepReset;
    stereo         = 1'b1;
    clear_resampler();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_settings();
    test_fractional_extremes();
    test_mono_upsample_cap();
    test_zero_step();
    test_max_step();
    test_block_boundary();
    test_random_ratios();
    drain_outputs();

    $display("Sent %0d input frames over %0d ratio/mode settings.", frames_sent,
             settings_used);
    $display("Checked %0d output frames, %0d of them closing a block.", frames_checked,
             blocks_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[linear_interp_resampler.f]
rtl/lir_pkg.sv
rtl/lir_front.sv
rtl/lir_back.sv
rtl/linear_interp_resampler.sv
dv/tb_linear_interp_resampler.sv
